[hdl/ils_pkg.sv]
`default_nettype none

package ils_pkg;

    localparam int MAX_ENTRIES_DEFAULT = 16;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 4;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;

    localparam logic [CMD_W-1:0] CMD_APPEND    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PREPEND   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT_AT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE_AT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_POP       = 3'd5;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_GET_AT    = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_IDX = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] item_value;
    } in_beat_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] read_value;
        logic [FILL_W-1:0]         fill_count;
    } out_beat_t;

endpackage

`default_nettype wire

[hdl/ils_core.sv]
`default_nettype none

module ils_core #(
    parameter int MAX_ENTRIES = ils_pkg::MAX_ENTRIES_DEFAULT
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   accept,
    input  ils_pkg::in_beat_t     in_beat,
    output ils_pkg::out_beat_t    result
);

    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int IW   = (CW > ils_pkg::POS_W) ? CW : ils_pkg::POS_W;
    localparam int IDXW = $clog2(MAX_ENTRIES);
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_ENTRIES);

    logic [ils_pkg::VALUE_W-1:0] entries_reg [MAX_ENTRIES];
    logic [ils_pkg::VALUE_W-1:0] entries_next [MAX_ENTRIES];
    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;

    logic [IW-1:0]               pos_w;
    logic [IW-1:0]               count_w;
    logic                        full;
    logic                        empty;
    logic                        pos_ok;
    logic                        do_ins;
    logic                        do_rem;
    logic                        do_clr;
    logic                        rd_en;
    logic [IW-1:0]               at;
    logic [IW-1:0]               rd_sel;
    logic [ils_pkg::STATUS_W-1:0] status;
    logic [ils_pkg::VALUE_W-1:0] rd_data;

    assign pos_w   = IW'(in_beat.position);
    assign count_w = IW'(count_reg);
    assign full    = (count_reg == MAX_COUNT);
    assign empty   = (count_reg == '0);
    assign pos_ok  = (pos_w < count_w);

    always_comb begin
        status = ils_pkg::ST_OK;
        do_ins = 1'b0;
        do_rem = 1'b0;
        do_clr = 1'b0;
        rd_en  = 1'b0;
        at     = '0;
        rd_sel = '0;
        case (in_beat.command)
            ils_pkg::CMD_APPEND: begin
                if (full) begin
                    status = ils_pkg::ST_FULL;
                end else begin
                    do_ins = 1'b1;
                    at     = count_w;
                end
            end
            ils_pkg::CMD_PREPEND: begin
                if (full) begin
                    status = ils_pkg::ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            ils_pkg::CMD_INSERT_AT: begin
                if (!pos_ok) begin
                    status = ils_pkg::ST_BAD_IDX;
                end else if (full) begin
                    status = ils_pkg::ST_FULL;
                end else begin
                    do_ins = 1'b1;
                    at     = pos_w;
                end
            end
            ils_pkg::CMD_REMOVE_AT: begin
                if (!pos_ok) begin
                    status = ils_pkg::ST_BAD_IDX;
                end else begin
                    do_rem = 1'b1;
                    at     = pos_w;
                end
            end
            ils_pkg::CMD_CLEAR: begin
                do_clr = 1'b1;
            end
            ils_pkg::CMD_POP: begin
                if (empty) begin
                    status = ils_pkg::ST_EMPTY;
                end else begin
                    do_rem = 1'b1;
                    at     = count_w - IW'(1);
                    rd_en  = 1'b1;
                    rd_sel = count_w - IW'(1);
                end
            end
            ils_pkg::CMD_DEQUEUE: begin
                if (empty) begin
                    status = ils_pkg::ST_EMPTY;
                end else begin
                    do_rem = 1'b1;
                    rd_en  = 1'b1;
                end
            end
            default: begin
                if (empty) begin
                    status = ils_pkg::ST_EMPTY;
                end else if (!pos_ok) begin
                    status = ils_pkg::ST_BAD_IDX;
                end else begin
                    rd_en  = 1'b1;
                    rd_sel = pos_w;
                end
            end
        endcase
    end

    always_comb begin
        if (do_clr) begin
            count_next = '0;
        end else if (do_ins) begin
            count_next = count_reg + CW'(1);
        end else if (do_rem) begin
            count_next = count_reg - CW'(1);
        end else begin
            count_next = count_reg;
        end
    end

    // Insertion opens a gap at the target index; removal closes one there.
    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_entry
        localparam logic [IW-1:0] IDX = IW'(i);
        logic [ils_pkg::VALUE_W-1:0] below;
        logic [ils_pkg::VALUE_W-1:0] above;

        if (i == 0) begin : g_first
            assign below = entries_reg[i];
        end else begin : g_mid
            assign below = entries_reg[i-1];
        end

        if (i == MAX_ENTRIES - 1) begin : g_last
            assign above = entries_reg[i];
        end else begin : g_body
            assign above = entries_reg[i+1];
        end

        always_comb begin
            entries_next[i] = entries_reg[i];
            if (do_ins) begin
                if (IDX == at) begin
                    entries_next[i] = in_beat.item_value;
                end else if (IDX > at) begin
                    entries_next[i] = below;
                end
            end else if (do_rem) begin
                if (IDX >= at) begin
                    entries_next[i] = above;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (accept) begin
                entries_reg[i] <= entries_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (accept) begin
            count_reg <= count_next;
        end
    end

    assign rd_data = rd_en ? entries_reg[rd_sel[IDXW-1:0]] : '0;

    assign result.status     = status;
    assign result.read_value = rd_data;
    assign result.fill_count = ils_pkg::FILL_W'(count_next);

endmodule

`default_nettype wire

[hdl/ils_out_reg.sv]
`default_nettype none

module ils_out_reg (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   load,
    input  ils_pkg::out_beat_t    load_data,
    output logic                  m_valid,
    input  wire                   m_ready,
    output ils_pkg::out_beat_t    m_data,
    output logic                  free
);

    logic               valid_reg;
    ils_pkg::out_beat_t data_reg;

    assign free    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

endmodule

`default_nettype wire

[hdl/indexed_list_store_unit.sv]
// A result beat is registered and presented in the cycle after its command is taken.
// All entries shift in parallel in the same cycle. A command is taken, one per cycle,
// whenever the output register is empty or being drained.
// Reset (synchronous, active low) empties the list and the output register;
// entry contents are not cleared and are read only after being written.
`default_nettype none

module indexed_list_store_unit #(
    parameter int MAX_ENTRIES = ils_pkg::MAX_ENTRIES_DEFAULT
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  ils_pkg::in_beat_t     s_data,
    output logic                  m_valid,
    input  wire                   m_ready,
    output ils_pkg::out_beat_t    m_data
);

    logic               accept;
    logic               free;
    ils_pkg::out_beat_t result;

    assign s_ready = free;
    assign accept  = s_valid && free;

    ils_core #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_core (
        .aclk   (aclk),
        .aresetn(aresetn),
        .accept (accept),
        .in_beat(s_data),
        .result (result)
    );

    ils_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .load_data(result),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .free     (free)
    );

endmodule

`default_nettype wire

[sim/tb_indexed_list_store_unit.sv]
`default_nettype none

module tb_indexed_list_store_unit;

    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_PER_PHASE = 300;

    class list_scoreboard;
        int errors = 0;
        logic signed [ils_pkg::VALUE_W-1:0] held[$];
        ils_pkg::out_beat_t expected[$];

        function int fill();
            return held.size();
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function void note_command(ils_pkg::in_beat_t cmd);
            ils_pkg::out_beat_t want;
            bit full;
            want = '0;
            want.status = ils_pkg::ST_OK;
            full = held.size() >= ils_pkg::MAX_ENTRIES_DEFAULT;
            case (cmd.command)
                ils_pkg::CMD_APPEND: begin
                    if (full) want.status = ils_pkg::ST_FULL;
                    else held.push_back(cmd.item_value);
                end
                ils_pkg::CMD_PREPEND: begin
                    if (full) want.status = ils_pkg::ST_FULL;
                    else held.push_front(cmd.item_value);
                end
                ils_pkg::CMD_INSERT_AT: begin
                    if (cmd.position >= held.size()) want.status = ils_pkg::ST_BAD_IDX;
                    else if (full) want.status = ils_pkg::ST_FULL;
                    else held.insert(cmd.position, cmd.item_value);
                end
                ils_pkg::CMD_REMOVE_AT: begin
                    if (cmd.position >= held.size()) want.status = ils_pkg::ST_BAD_IDX;
                    else held.delete(cmd.position);
                end
                ils_pkg::CMD_CLEAR: begin
                    held.delete();
                end
                ils_pkg::CMD_POP: begin
                    if (held.size() == 0) want.status = ils_pkg::ST_EMPTY;
                    else want.read_value = held.pop_back();
                end
                ils_pkg::CMD_DEQUEUE: begin
                    if (held.size() == 0) want.status = ils_pkg::ST_EMPTY;
                    else want.read_value = held.pop_front();
                end
                ils_pkg::CMD_GET_AT: begin
                    if (held.size() == 0) want.status = ils_pkg::ST_EMPTY;
                    else if (cmd.position >= held.size()) want.status = ils_pkg::ST_BAD_IDX;
                    else want.read_value = held[cmd.position];
                end
                default: begin
                end
            endcase
            want.fill_count = ils_pkg::FILL_W'(held.size());
            expected.push_back(want);
        endfunction

        function void check_result(ils_pkg::out_beat_t got);
            ils_pkg::out_beat_t want;
            if (expected.size() == 0) begin
                $error("Result beat arrived with no command outstanding.");
                errors++;
                return;
            end
            want = expected.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.read_value !== want.read_value) begin
                $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
                errors++;
            end
            if (got.fill_count !== want.fill_count) begin
                $error("fill_count: expected %0d, got %0d", want.fill_count, got.fill_count);
                errors++;
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    ils_pkg::in_beat_t  s_data;
    logic               m_valid;
    logic               m_ready = 1'b0;
    ils_pkg::out_beat_t m_data;

    int src_idle_pct;
    int dst_idle_pct;
    int quiet_cycles = 0;
    bit growing;

    list_scoreboard sb = new();

    indexed_list_store_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_data);
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_cmd(input ils_pkg::in_beat_t cmd);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= cmd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_command(cmd);
    endtask

    task automatic send_fields(input logic [ils_pkg::CMD_W-1:0] command, input int position,
                               input logic signed [ils_pkg::VALUE_W-1:0] value);
        ils_pkg::in_beat_t cmd;
        cmd.command    = command;
        cmd.position   = position[ils_pkg::POS_W-1:0];
        cmd.item_value = value;
        send_cmd(cmd);
    endtask

    function automatic ils_pkg::in_beat_t random_cmd(int fill, bit grow);
        ils_pkg::in_beat_t cmd;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            cmd.command = ils_pkg::CMD_CLEAR;
        end else if (roll < (grow ? 65 : 30)) begin
            case ($urandom_range(0, 2))
                0: cmd.command = ils_pkg::CMD_APPEND;
                1: cmd.command = ils_pkg::CMD_PREPEND;
                default: cmd.command = ils_pkg::CMD_INSERT_AT;
            endcase
        end else begin
            case ($urandom_range(0, 3))
                0: cmd.command = ils_pkg::CMD_REMOVE_AT;
                1: cmd.command = ils_pkg::CMD_POP;
                2: cmd.command = ils_pkg::CMD_DEQUEUE;
                default: cmd.command = ils_pkg::CMD_GET_AT;
            endcase
        end
        if (fill > 0 && $urandom_range(0, 3) != 0) begin
            cmd.position = ils_pkg::POS_W'($urandom_range(0, fill - 1));
        end else begin
            cmd.position = ils_pkg::POS_W'($urandom_range(0, 15));
        end
        case ($urandom_range(0, 7))
            0: cmd.item_value = 32'sh7FFF_FFFF;
            1: cmd.item_value = 32'sh8000_0000;
            2: cmd.item_value = '0;
            3: cmd.item_value = '1;
            default: cmd.item_value = $urandom;
        endcase
        return cmd;
    endfunction

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        src_idle_pct = 31;
        dst_idle_pct = 53;
        growing      = 1'b1;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Every command but prepend against an empty list, then a short list with
        // extreme values and out-of-range indexes.
        send_fields(ils_pkg::CMD_POP, 0, 0);
        send_fields(ils_pkg::CMD_DEQUEUE, 0, 0);
        send_fields(ils_pkg::CMD_GET_AT, 0, 0);
        send_fields(ils_pkg::CMD_REMOVE_AT, 0, 0);
        send_fields(ils_pkg::CMD_INSERT_AT, 0, 32'sd5);
        send_fields(ils_pkg::CMD_CLEAR, 15, 0);
        send_fields(ils_pkg::CMD_APPEND, 0, 32'sh7FFF_FFFF);
        send_fields(ils_pkg::CMD_PREPEND, 15, 32'sh8000_0000);
        send_fields(ils_pkg::CMD_INSERT_AT, 1, -32'sd1);
        send_fields(ils_pkg::CMD_INSERT_AT, 15, 32'sd9);
        send_fields(ils_pkg::CMD_GET_AT, 0, 0);
        send_fields(ils_pkg::CMD_GET_AT, 2, 0);
        send_fields(ils_pkg::CMD_GET_AT, 15, 0);
        send_fields(ils_pkg::CMD_REMOVE_AT, 15, 0);
        send_fields(ils_pkg::CMD_REMOVE_AT, 1, 0);
        send_fields(ils_pkg::CMD_POP, 0, 0);
        send_fields(ils_pkg::CMD_DEQUEUE, 0, 0);
        send_fields(ils_pkg::CMD_POP, 0, 0);
        send_fields(ils_pkg::CMD_APPEND, 0, 32'sd1234);
        send_fields(ils_pkg::CMD_CLEAR, 0, 0);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct = 31;
                    dst_idle_pct = 53;
                end
                1: begin
                    src_idle_pct = 53;
                    dst_idle_pct = 31;
                end
                default: begin
                    src_idle_pct = 0;
                    dst_idle_pct = 0;
                end
            endcase
            repeat (RANDOM_PER_PHASE) begin
                if (sb.fill() == 0) growing = 1'b1;
                else if (sb.fill() >= ils_pkg::MAX_ENTRIES_DEFAULT &&
                         $urandom_range(0, 7) == 0)
                    growing = 1'b0;
                send_cmd(random_cmd(sb.fill(), growing));
            end
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
